[rtl/core/ocf_pkg.sv]
// ----------------------------------------------------------------------------
// ocf_pkg
// Shared types and constants of the overlap chain filter: register indexes,
// verdict reason codes and the per-group control state.
// ----------------------------------------------------------------------------
package ocf_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 25;
   localparam int LENGTH_BITS    = 24;
   localparam int LIMIT_BITS     = 24;
   localparam int PERCENT_BITS   = 7;
   localparam int REASON_BITS    = 3;
   localparam int COUNT_OUT_BITS = 11;
   localparam int SUM_BITS       = 35;
   localparam int RSP_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_READ_LENGTH     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_READ_LENGTH     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_UNALIGNED_TIPS  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_OVERHANG        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_GAP             = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_COVERED_PERCENT = 3'd5;

   localparam logic [REASON_BITS-1:0] REASON_KEPT          = 3'd0;
   localparam logic [REASON_BITS-1:0] REASON_READ_LENGTH   = 3'd1;
   localparam logic [REASON_BITS-1:0] REASON_TIPS          = 3'd2;
   localparam logic [REASON_BITS-1:0] REASON_ORIENTATION   = 3'd3;
   localparam logic [REASON_BITS-1:0] REASON_GAP           = 3'd4;
   localparam logic [REASON_BITS-1:0] REASON_BAD_EXTENSION = 3'd5;
   localparam logic [REASON_BITS-1:0] REASON_CYCLIC_BREAKS = 3'd6;
   localparam logic [REASON_BITS-1:0] REASON_COVERAGE      = 3'd7;

   localparam logic [1:0] BREAKS_LIMIT = 2'd2;

   localparam logic signed [CSR_DATA_BITS-1:0] LENGTH_CHECK_OFF = -25'sd1;

   localparam logic signed [CSR_DATA_BITS-1:0] RESET_MIN_READ_LENGTH = -25'sd1;
   localparam logic signed [CSR_DATA_BITS-1:0] RESET_MAX_READ_LENGTH = -25'sd1;
   localparam logic [LIMIT_BITS-1:0]   RESET_MAX_UNALIGNED_TIPS  = 24'd1000;
   localparam logic [LIMIT_BITS-1:0]   RESET_MAX_OVERHANG        = 24'd25;
   localparam logic [LIMIT_BITS-1:0]   RESET_MAX_GAP             = 24'd1000;
   localparam logic [PERCENT_BITS-1:0] RESET_MIN_COVERED_PERCENT = 7'd75;

   typedef struct packed {
      logic                   in_group;
      logic                   rejected;
      logic [REASON_BITS-1:0] reason;
      logic                   orientation;
      logic [1:0]             breaks;
   } ctl_type;

endpackage

[rtl/core/ocf_eval.sv]
// ----------------------------------------------------------------------------
// ocf_eval
// Chain checks for one alignment record: next group state and the verdict
// that the record gives when it closes its group.
// ----------------------------------------------------------------------------
module ocf_eval #(
   parameter int POSITION_BITS = 24
) (
   input  logic signed [ocf_pkg::CSR_DATA_BITS-1:0] min_read_length,
   input  logic signed [ocf_pkg::CSR_DATA_BITS-1:0] max_read_length,
   input  logic [ocf_pkg::LIMIT_BITS-1:0]           max_unaligned_tips,
   input  logic [ocf_pkg::LIMIT_BITS-1:0]           max_overhang,
   input  logic [ocf_pkg::LIMIT_BITS-1:0]           max_gap,
   input  logic [ocf_pkg::PERCENT_BITS-1:0]         min_covered_percent,
   input  logic [POSITION_BITS-1:0]                 ref_begin,
   input  logic [POSITION_BITS-1:0]                 ref_end,
   input  logic [POSITION_BITS-1:0]                 query_begin,
   input  logic [POSITION_BITS-1:0]                 query_end,
   input  logic                                     complemented,
   input  logic [ocf_pkg::LENGTH_BITS-1:0]          ref_length,
   input  logic [ocf_pkg::LENGTH_BITS-1:0]          query_length,
   input  logic                                     last_in_group,
   input  ocf_pkg::ctl_type                         ctl_cur,
   input  logic [POSITION_BITS-1:0]                 first_qb_cur,
   input  logic [POSITION_BITS-1:0]                 prev_re_cur,
   input  logic [POSITION_BITS-1:0]                 prev_qe_cur,
   input  logic signed [ocf_pkg::SUM_BITS-1:0]      sum_cur,
   output ocf_pkg::ctl_type                         ctl_nxt,
   output logic [POSITION_BITS-1:0]                 first_qb_nxt,
   output logic [POSITION_BITS-1:0]                 prev_re_nxt,
   output logic [POSITION_BITS-1:0]                 prev_qe_nxt,
   output logic signed [ocf_pkg::SUM_BITS-1:0]      sum_nxt,
   output logic                                     keep,
   output logic [ocf_pkg::REASON_BITS-1:0]          reason
);
   import ocf_pkg::*;

   localparam int W        = ((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS) + 2;
   localparam int ACC_BITS = SUM_BITS + 1;
   localparam int PROD_BITS = SUM_BITS + 8;
   localparam int RHS_BITS = PERCENT_BITS + LENGTH_BITS;

   logic signed [W-1:0] rb_s, re_s, qb_s, qe_s, rlen_s, qlen_s;
   logic signed [W-1:0] tips_s, ovh_s, gap_s, min_s, max_s;
   logic signed [W-1:0] fqb_s, pre_s, pqe_s, span_s;
   logic signed [ACC_BITS-1:0] acc;
   logic signed [SUM_BITS-1:0] sum_sat;
   logic signed [PROD_BITS-1:0] lhs, rhs;
   logic [RHS_BITS-1:0] need;
   logic cov_low;
   ctl_type c;

   assign rb_s   = W'($signed({1'b0, ref_begin}));
   assign re_s   = W'($signed({1'b0, ref_end}));
   assign qb_s   = W'($signed({1'b0, query_begin}));
   assign qe_s   = W'($signed({1'b0, query_end}));
   assign rlen_s = W'($signed({1'b0, ref_length}));
   assign qlen_s = W'($signed({1'b0, query_length}));
   assign tips_s = W'($signed({1'b0, max_unaligned_tips}));
   assign ovh_s  = W'($signed({1'b0, max_overhang}));
   assign gap_s  = W'($signed({1'b0, max_gap}));
   assign min_s  = W'(min_read_length);
   assign max_s  = W'(max_read_length);
   assign fqb_s  = W'($signed({1'b0, first_qb_cur}));
   assign pre_s  = W'($signed({1'b0, prev_re_cur}));
   assign pqe_s  = W'($signed({1'b0, prev_qe_cur}));
   assign span_s = qe_s - qb_s;

   // saturating add of this record's span; a new group starts from zero
   assign acc = (ctl_cur.in_group ? ACC_BITS'(sum_cur) : ACC_BITS'(0)) + ACC_BITS'(span_s);
   always_comb begin
      if (acc[ACC_BITS-1] != acc[ACC_BITS-2]) begin
         sum_sat = acc[ACC_BITS-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                   : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         sum_sat = acc[SUM_BITS-1:0];
      end
   end

   always_comb begin
      c            = ctl_cur;
      first_qb_nxt = first_qb_cur;
      prev_re_nxt  = prev_re_cur;
      prev_qe_nxt  = prev_qe_cur;
      sum_nxt      = sum_cur;
      if (!ctl_cur.in_group) begin
         c.rejected    = 1'b0;
         c.reason      = REASON_KEPT;
         c.breaks      = 2'd0;
         c.orientation = complemented;
         first_qb_nxt  = query_begin;
         prev_re_nxt   = ref_end;
         prev_qe_nxt   = query_end;
         sum_nxt       = sum_sat;
         priority if (min_read_length != LENGTH_CHECK_OFF &&
                      (qlen_s < min_s || qlen_s > max_s)) begin
            c.rejected = 1'b1;
            c.reason   = REASON_READ_LENGTH;
         end else if (rb_s > tips_s && qb_s > tips_s) begin
            c.rejected = 1'b1;
            c.reason   = REASON_TIPS;
         end else begin
         end
      end else if (!ctl_cur.rejected) begin
         sum_nxt = sum_sat;
         priority if (complemented != ctl_cur.orientation) begin
            c.rejected = 1'b1;
            c.reason   = REASON_ORIENTATION;
         end else if (rb_s - pre_s > gap_s) begin
            c.rejected = 1'b1;
            c.reason   = REASON_GAP;
         end else if (pre_s - ovh_s < rb_s) begin
            priority if (pqe_s - ovh_s < qb_s) begin
               if (qb_s - pqe_s > gap_s) begin
                  c.rejected = 1'b1;
                  c.reason   = REASON_GAP;
               end else begin
                  prev_re_nxt = ref_end;
                  prev_qe_nxt = query_end;
               end
            end else if (qlen_s - pqe_s < tips_s && qe_s - tips_s < fqb_s) begin
               prev_re_nxt = ref_end;
               prev_qe_nxt = query_end;
               if (ctl_cur.breaks != BREAKS_LIMIT) begin
                  c.breaks = ctl_cur.breaks + 2'd1;
               end
            end else begin
               c.rejected = 1'b1;
               c.reason   = REASON_BAD_EXTENSION;
            end
         end else begin
            c.rejected = 1'b1;
            c.reason   = REASON_BAD_EXTENSION;
         end
      end
   end

   assign need    = RHS_BITS'(min_covered_percent) * RHS_BITS'(query_length);
   assign lhs     = PROD_BITS'(sum_nxt) * PROD_BITS'(100);
   assign rhs     = PROD_BITS'($signed({1'b0, need}));
   assign cov_low = lhs < rhs;

   always_comb begin
      ctl_nxt          = c;
      ctl_nxt.in_group = !last_in_group;
      if (last_in_group && !c.rejected) begin
         if (!ctl_cur.in_group) begin
            priority if (rlen_s - re_s > tips_s && qlen_s - qe_s > tips_s) begin
               ctl_nxt.rejected = 1'b1;
               ctl_nxt.reason   = REASON_TIPS;
            end else if (cov_low) begin
               ctl_nxt.rejected = 1'b1;
               ctl_nxt.reason   = REASON_COVERAGE;
            end else begin
            end
         end else begin
            priority if (c.breaks > 2'd1) begin
               ctl_nxt.rejected = 1'b1;
               ctl_nxt.reason   = REASON_CYCLIC_BREAKS;
            end else if (cov_low) begin
               ctl_nxt.rejected = 1'b1;
               ctl_nxt.reason   = REASON_COVERAGE;
            end else begin
            end
         end
      end
      keep   = !ctl_nxt.rejected;
      reason = ctl_nxt.rejected ? ctl_nxt.reason : REASON_KEPT;
   end

endmodule

[rtl/core/overlap_chain_filter.sv]
// ----------------------------------------------------------------------------
// overlap_chain_filter
// Keep or discard verdict for the chain of alignment records of one query.
// ----------------------------------------------------------------------------
// Records of one query read stream in on req_, the last one flagged by
// req_tlast; each closed group gives one verdict on rsp_ (keep, reason and
// the saturating record count). The block takes one record every cycle while
// no stalled result register holds a closing record back: each record passes
// an input register, combinational chain checks against the previous record,
// and a result register that presents the group's verdict on rsp_. Only a
// stalled result register holding a verdict blocks a further closing record.
// Registers must be written through csr_ between groups; nothing enforces it.
module overlap_chain_filter #(
   parameter int MAX_GROUP_ITEMS = 1024,
   parameter int POSITION_BITS   = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic                                    csr_wen,
   input  logic [ocf_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [ocf_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // ref_begin, ref_end, query_begin, query_end, ref_length, query_length, pad
   input  logic [((4*POSITION_BITS+2*ocf_pkg::LENGTH_BITS+7)/8)*8-1:0] req_tdata,
   // complemented
   input  logic                                    req_tuser,
   input  logic                                    req_tlast,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // keep, reason, group_count, pad
   output logic [ocf_pkg::RSP_DATA_BITS-1:0]       rsp_tdata
);
   import ocf_pkg::*;

   localparam int P  = POSITION_BITS;
   localparam int CW = $clog2(MAX_GROUP_ITEMS + 1);

   logic signed [CSR_DATA_BITS-1:0] min_len_ff, max_len_ff;
   logic [LIMIT_BITS-1:0]   tips_ff, ovh_ff, gap_ff;
   logic [PERCENT_BITS-1:0] pct_ff;

   logic                   s1_valid_ff;
   logic [P-1:0]           rb_ff, re_ff, qb_ff, qe_ff;
   logic                   comp_ff, last_ff;
   logic [LENGTH_BITS-1:0] rlen_ff, qlen_ff;

   ctl_type                    ctl_ff, ctl_in;
   logic [P-1:0]               fqb_ff, fqb_in, pre_ff, pre_in, pqe_ff, pqe_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [CW-1:0]              cnt_ff, cnt_in, cnt_base;
   logic [CW+COUNT_OUT_BITS-1:0] cnt_wide;

   logic                    rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                    keep;
   logic [REASON_BITS-1:0]  reason;
   logic                    out_free, s1_fire, req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= RESET_MIN_READ_LENGTH;
         max_len_ff <= RESET_MAX_READ_LENGTH;
         tips_ff    <= RESET_MAX_UNALIGNED_TIPS;
         ovh_ff     <= RESET_MAX_OVERHANG;
         gap_ff     <= RESET_MAX_GAP;
         pct_ff     <= RESET_MIN_COVERED_PERCENT;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_MIN_READ_LENGTH:     min_len_ff <= csr_wdata;
            CSR_MAX_READ_LENGTH:     max_len_ff <= csr_wdata;
            CSR_MAX_UNALIGNED_TIPS:  tips_ff    <= csr_wdata[LIMIT_BITS-1:0];
            CSR_MAX_OVERHANG:        ovh_ff     <= csr_wdata[LIMIT_BITS-1:0];
            CSR_MAX_GAP:             gap_ff     <= csr_wdata[LIMIT_BITS-1:0];
            CSR_MIN_COVERED_PERCENT: pct_ff     <= csr_wdata[PERCENT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && (!last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   // hold the record until the checks can retire it
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rb_ff   <= req_tdata[P-1:0];
         re_ff   <= req_tdata[2*P-1:P];
         qb_ff   <= req_tdata[3*P-1:2*P];
         qe_ff   <= req_tdata[4*P-1:3*P];
         rlen_ff <= req_tdata[4*P+LENGTH_BITS-1:4*P];
         qlen_ff <= req_tdata[4*P+2*LENGTH_BITS-1:4*P+LENGTH_BITS];
         comp_ff <= req_tuser;
         last_ff <= req_tlast;
      end
   end

   ocf_eval #(
      .POSITION_BITS(POSITION_BITS)
   ) u_eval (
      .min_read_length     (min_len_ff),
      .max_read_length     (max_len_ff),
      .max_unaligned_tips  (tips_ff),
      .max_overhang        (ovh_ff),
      .max_gap             (gap_ff),
      .min_covered_percent (pct_ff),
      .ref_begin           (rb_ff),
      .ref_end             (re_ff),
      .query_begin         (qb_ff),
      .query_end           (qe_ff),
      .complemented        (comp_ff),
      .ref_length          (rlen_ff),
      .query_length        (qlen_ff),
      .last_in_group       (last_ff),
      .ctl_cur             (ctl_ff),
      .first_qb_cur        (fqb_ff),
      .prev_re_cur         (pre_ff),
      .prev_qe_cur         (pqe_ff),
      .sum_cur             (sum_ff),
      .ctl_nxt             (ctl_in),
      .first_qb_nxt        (fqb_in),
      .prev_re_nxt         (pre_in),
      .prev_qe_nxt         (pqe_in),
      .sum_nxt             (sum_in),
      .keep                (keep),
      .reason              (reason)
   );

   assign cnt_base = ctl_ff.in_group ? cnt_ff : CW'(0);
   assign cnt_in   = (cnt_base < CW'(MAX_GROUP_ITEMS)) ? cnt_base + CW'(1) : cnt_base;
   assign cnt_wide = (CW + COUNT_OUT_BITS)'(cnt_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
         cnt_ff <= '0;
      end else if (s1_fire) begin
         ctl_ff <= ctl_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         fqb_ff <= fqb_in;
         pre_ff <= pre_in;
         pqe_ff <= pqe_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && last_ff) begin
         rsp_data_ff <= {1'b0, cnt_wide[COUNT_OUT_BITS-1:0], reason, keep};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_keep_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[3:1] == REASON_KEPT)))
      else $error("verdict and reason disagree");

   a_breaks_sat: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.breaks != 2'd3)
      else $error("cyclic break count passed its limit");

   a_reject_sticky: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && ctl_ff.in_group && ctl_ff.rejected) |=> ctl_ff.rejected)
      else $error("rejected group became accepted");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(s1_fire && last_ff))
      else $error("verdict overwritten while stalled");
`endif

endmodule

[bench/overlap_chain_filter_tb.sv]
// ----------------------------------------------------------------------------
// overlap_chain_filter_tb
// Self-checking bench for the per-query alignment chain verdict.
// ----------------------------------------------------------------------------
// Alignment records stream into req_ from a queue of pending records, with
// random idle bursts on the sender and stall bursts on the receiver. An
// in-bench predictor tracks the chain state of each group and works out the
// keep flag, reject reason and record count that each closing record must
// give. Verdicts from rsp_ are checked in order against those expectations.
// The run steps through directed cases, one very long group that saturates
// the record count and the coverage sum, and random chains under several
// register settings.
// ----------------------------------------------------------------------------
module overlap_chain_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ocf_pkg::*;

   localparam int MAX_GROUP_ITEMS = 1024;
   localparam longint COVER_MAX = 64'sd17179869183;
   localparam longint COVER_MIN = -COVER_MAX - 1;
   localparam logic [23:0] POS_TOP = 24'hFFFFFF;

   typedef struct {
      logic [23:0] ref_begin;
      logic [23:0] ref_end;
      logic [23:0] query_begin;
      logic [23:0] query_end;
      logic        complemented;
      logic [23:0] ref_length;
      logic [23:0] query_length;
      logic        last;
   } alignment_type;

   typedef struct {
      logic                      keep;
      logic [REASON_BITS-1:0]    reason;
      logic [COUNT_OUT_BITS-1:0] count;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // ref_begin, ref_end, query_begin, query_end, ref_length, query_length
   logic [143:0]              req_tdata = '0;
   // complemented
   logic                      req_tuser = 1'b0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // keep, reason, group_count, pad
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;

   overlap_chain_filter dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register shadow
   longint cfg_min_len = -1;
   longint cfg_max_len = -1;
   longint cfg_tips = 1000;
   longint cfg_overhang = 25;
   longint cfg_gap = 1000;
   longint cfg_min_pct = 75;

   // chain state
   bit                     chain_open;
   bit                     chain_rejected;
   logic [REASON_BITS-1:0] chain_reason;
   longint                 chain_first_qb;
   longint                 chain_prev_re;
   longint                 chain_prev_qe;
   logic                   chain_orient;
   longint                 chain_cover;
   logic [1:0]             chain_breaks;
   int                     chain_count;

   alignment_type record_q[$];
   verdict_type   verdict_q[$];
   alignment_type held_rec;
   int  pushed_total;
   int  accepted_total;
   int  errors;
   int  reason_seen[8];
   int  send_hold;
   int  stall_hold;
   bit  idle_on = 1'b1;

   function automatic void reject_chain(input logic [REASON_BITS-1:0] why);
      if (!chain_rejected) begin
         chain_rejected = 1'b1;
         chain_reason = why;
      end
   endfunction

   function automatic void add_coverage(input longint d);
      longint s;
      s = chain_cover + d;
      if (s > COVER_MAX) s = COVER_MAX;
      if (s < COVER_MIN) s = COVER_MIN;
      chain_cover = s;
   endfunction

   function automatic bit coverage_short(input longint qlen);
      return chain_cover * 100 < cfg_min_pct * qlen;
   endfunction

   function automatic void judge_alignment(input alignment_type a);
      longint      rb, re, qb, qe, rlen, qlen;
      bit          single;
      verdict_type v;
      rb = longint'(a.ref_begin);
      re = longint'(a.ref_end);
      qb = longint'(a.query_begin);
      qe = longint'(a.query_end);
      rlen = longint'(a.ref_length);
      qlen = longint'(a.query_length);
      single = !chain_open;
      if (!chain_open) begin
         chain_open = 1'b1;
         chain_rejected = 1'b0;
         chain_reason = REASON_KEPT;
         chain_breaks = '0;
         chain_cover = 0;
         chain_count = 0;
         chain_orient = a.complemented;
         chain_first_qb = qb;
         chain_prev_re = re;
         chain_prev_qe = qe;
         if (cfg_min_len != LENGTH_CHECK_OFF && (qlen < cfg_min_len || qlen > cfg_max_len))
            reject_chain(REASON_READ_LENGTH);
         if (!chain_rejected && rb > cfg_tips && qb > cfg_tips) reject_chain(REASON_TIPS);
         add_coverage(qe - qb);
      end else if (!chain_rejected) begin
         add_coverage(qe - qb);
         if (a.complemented != chain_orient) begin
            reject_chain(REASON_ORIENTATION);
         end else if (rb - chain_prev_re > cfg_gap) begin
            reject_chain(REASON_GAP);
         end else if (chain_prev_re - cfg_overhang < rb) begin
            if (chain_prev_qe - cfg_overhang < qb) begin
               if (qb - chain_prev_qe > cfg_gap) begin
                  reject_chain(REASON_GAP);
               end else begin
                  chain_prev_re = re;
                  chain_prev_qe = qe;
               end
            end else if (qlen - chain_prev_qe < cfg_tips && qe - cfg_tips < chain_first_qb) begin
               chain_prev_re = re;
               chain_prev_qe = qe;
               if (chain_breaks < BREAKS_LIMIT) chain_breaks++;
            end else begin
               reject_chain(REASON_BAD_EXTENSION);
            end
         end else begin
            reject_chain(REASON_BAD_EXTENSION);
         end
      end
      if (chain_count < MAX_GROUP_ITEMS) chain_count++;
      if (a.last) begin
         if (!chain_rejected) begin
            if (single) begin
               if (rlen - re > cfg_tips && qlen - qe > cfg_tips) reject_chain(REASON_TIPS);
               else if (coverage_short(qlen)) reject_chain(REASON_COVERAGE);
            end else begin
               if (chain_breaks >= BREAKS_LIMIT) reject_chain(REASON_CYCLIC_BREAKS);
               else if (coverage_short(qlen)) reject_chain(REASON_COVERAGE);
            end
         end
         v.keep = !chain_rejected;
         v.reason = chain_rejected ? chain_reason : REASON_KEPT;
         v.count = COUNT_OUT_BITS'(chain_count);
         verdict_q.push_back(v);
         chain_open = 1'b0;
      end
   endfunction

   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
         send_hold = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            judge_alignment(held_rec);
            accepted_total++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_hold > 0) begin
               send_hold--;
               req_tvalid <= 1'b0;
            end else if (record_q.size() != 0) begin
               held_rec = record_q.pop_front();
               req_tdata <= {held_rec.query_length, held_rec.ref_length, held_rec.query_end,
                             held_rec.query_begin, held_rec.ref_end, held_rec.ref_begin};
               req_tuser <= held_rec.complemented;
               req_tlast <= held_rec.last;
               req_tvalid <= 1'b1;
               if (idle_on && $urandom_range(0, 9) == 0) send_hold = $urandom_range(1, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected verdict, expected none, got %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = verdict_q.pop_front();
               reason_seen[want.reason]++;
               if (rsp_tdata[0] !== want.keep) begin
                  $display("%0t: keep expected %0d got %0d", $time, want.keep, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[3:1] !== want.reason) begin
                  $display("%0t: reason expected %0d got %0d", $time, want.reason,
                           rsp_tdata[3:1]);
                  errors++;
               end
               if (rsp_tdata[14:4] !== want.count) begin
                  $display("%0t: group_count expected %0d got %0d", $time, want.count,
                           rsp_tdata[14:4]);
                  errors++;
               end
            end
         end
         if (stall_hold > 0) begin
            stall_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall_hold = $urandom_range(1, 11);
         end
      end
   end

   task automatic program_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                              input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MIN_READ_LENGTH:     cfg_min_len = longint'($signed(val));
         CSR_MAX_READ_LENGTH:     cfg_max_len = longint'($signed(val));
         CSR_MAX_UNALIGNED_TIPS:  cfg_tips = longint'(val[LIMIT_BITS-1:0]);
         CSR_MAX_OVERHANG:        cfg_overhang = longint'(val[LIMIT_BITS-1:0]);
         CSR_MAX_GAP:             cfg_gap = longint'(val[LIMIT_BITS-1:0]);
         CSR_MIN_COVERED_PERCENT: cfg_min_pct = longint'(val[PERCENT_BITS-1:0]);
         default: ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic set_filter(input longint mn, input longint mx, input longint tips,
                             input longint ovh, input longint gap, input longint pct);
      program_reg(CSR_MIN_READ_LENGTH, mn[CSR_DATA_BITS-1:0]);
      program_reg(CSR_MAX_READ_LENGTH, mx[CSR_DATA_BITS-1:0]);
      program_reg(CSR_MAX_UNALIGNED_TIPS, tips[CSR_DATA_BITS-1:0]);
      program_reg(CSR_MAX_OVERHANG, ovh[CSR_DATA_BITS-1:0]);
      program_reg(CSR_MAX_GAP, gap[CSR_DATA_BITS-1:0]);
      program_reg(CSR_MIN_COVERED_PERCENT, pct[CSR_DATA_BITS-1:0]);
   endtask

   task automatic queue_record(input logic [23:0] rb, input logic [23:0] re,
                               input logic [23:0] qb, input logic [23:0] qe,
                               input logic comp, input logic [23:0] rlen,
                               input logic [23:0] qlen, input logic last);
      alignment_type a;
      a.ref_begin = rb;
      a.ref_end = re;
      a.query_begin = qb;
      a.query_end = qe;
      a.complemented = comp;
      a.ref_length = rlen;
      a.query_length = qlen;
      a.last = last;
      record_q.push_back(a);
      pushed_total++;
   endtask

   task automatic wait_idle();
      while (accepted_total != pushed_total || verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic longint pick_limit(input int unsigned lo, input int unsigned hi);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return longint'(POS_TOP);
         default: return longint'($urandom_range(lo, hi));
      endcase
   endfunction

   // mostly well-formed chains with forward steps and the odd wrap, plus noise
   task automatic queue_group(input int n);
      alignment_type grp[$];
      alignment_type a;
      longint qb, qe, rb, re, first_qb, prev_qe, prev_re, top_q, len, qlen;
      bit comp;
      int pick;
      comp = 1'($urandom_range(0, 1));
      top_q = 0;
      first_qb = 0;
      prev_qe = 0;
      prev_re = 0;
      for (int i = 0; i < n; i++) begin
         len = longint'($urandom_range(200, 4000));
         pick = $urandom_range(0, 15);
         if (i == 0) begin
            qb = longint'($urandom_range(0, 1500));
            rb = longint'($urandom_range(0, 1500));
            first_qb = qb;
         end else if (pick == 0) begin
            qb = longint'($urandom_range(0, int'(first_qb)));
            len = longint'($urandom_range(0, 1200));
            rb = prev_re - longint'($urandom_range(0, 20));
         end else begin
            qb = prev_qe + ($urandom_range(0, 3) == 0 ? longint'($urandom_range(0, 1500))
                                                    : longint'($urandom_range(0, 60)) - 30);
            rb = prev_re + ($urandom_range(0, 3) == 0 ? longint'($urandom_range(0, 1500))
                                                    : longint'($urandom_range(0, 60)) - 30);
         end
         qe = qb + len;
         re = rb + len + longint'($urandom_range(0, 40)) - 20;
         a.ref_begin = rb[23:0];
         a.ref_end = re[23:0];
         a.query_begin = qb[23:0];
         a.query_end = qe[23:0];
         if (pick == 1) begin
            a.ref_begin = 24'($urandom);
            a.ref_end = 24'($urandom);
            a.query_begin = 24'($urandom);
            a.query_end = 24'($urandom);
         end
         a.complemented = ($urandom_range(0, 31) == 0) ? !comp : comp;
         a.ref_length = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                    : 24'(re + $urandom_range(0, 1500));
         a.last = (i == n - 1);
         prev_qe = longint'(a.query_end);
         prev_re = longint'(a.ref_end);
         if (prev_qe > top_q) top_q = prev_qe;
         grp.push_back(a);
      end
      case ($urandom_range(0, 19))
         0, 1:    qlen = longint'($urandom_range(0, 100));
         2, 3, 4: qlen = longint'($urandom & 32'hFFFFFF);
         default: qlen = top_q + longint'($urandom_range(0, 1500));
      endcase
      foreach (grp[i]) begin
         grp[i].query_length = qlen[23:0];
         record_q.push_back(grp[i]);
         pushed_total++;
      end
   endtask

   initial begin : stimulus
      longint mn;
      longint mx;
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      queue_record(0, 900, 0, 900, 0, 1000, 1000, 1);
      queue_record(2000, 2900, 2000, 2900, 0, 3000, 3000, 1);
      queue_record(0, 100, 0, 100, 0, 5000, 5000, 1);
      queue_record(0, 100, 0, 100, 0, 100, 1000, 1);
      queue_record(0, 500, 500, 0, 1, 500, 500, 1);
      queue_record(0, 0, 0, 0, 0, 0, 0, 1);
      queue_record(0, 0, 10, 0, 0, 0, 0, 1);
      queue_record(POS_TOP, POS_TOP, POS_TOP, POS_TOP, 1, POS_TOP, POS_TOP, 1);
      queue_record(0, 1000, 0, 1000, 0, 3000, 3000, 0);
      queue_record(1000, 2000, 1000, 2000, 1, 3000, 3000, 0);
      queue_record(9000, 9100, 0, 10, 0, 3000, 3000, 1);
      queue_record(0, 1000, 0, 1000, 0, 3000, 3000, 0);
      queue_record(5000, 6000, 1000, 2000, 0, 9000, 3000, 1);
      queue_record(0, 1000, 0, 1000, 0, 3000, 3000, 0);
      queue_record(500, 1500, 1000, 2000, 0, 3000, 3000, 1);
      queue_record(0, 9400, 100, 9500, 0, 20000, 10000, 0);
      queue_record(9400, 9500, 0, 900, 0, 20000, 10000, 1);
      queue_record(0, 9400, 100, 9500, 0, 20000, 10000, 0);
      queue_record(9400, 9500, 0, 900, 0, 20000, 10000, 0);
      queue_record(9500, 18000, 900, 9500, 0, 20000, 10000, 0);
      queue_record(18000, 18100, 0, 900, 0, 20000, 10000, 1);
      wait_idle();

      set_filter(5, -1, 1000, 25, 1000, 75);
      queue_record(0, 900, 0, 900, 0, 1000, 1000, 1);
      wait_idle();

      set_filter(0, POS_TOP, 0, 0, 0, 100);
      queue_record(0, 100, 0, 100, 0, 100, 100, 1);
      queue_record(0, 100, 0, 100, 0, 200, 200, 0);
      queue_record(100, 200, 100, 200, 0, 200, 200, 1);
      wait_idle();

      set_filter(POS_TOP, POS_TOP, POS_TOP, POS_TOP, POS_TOP, 50);
      queue_record(0, 10, 0, POS_TOP, 0, 10, POS_TOP, 1);
      wait_idle();

      // long group: count and coverage sum saturate
      set_filter(-1, -1, 1000, POS_TOP, POS_TOP, 100);
      for (int i = 0; i < MAX_GROUP_ITEMS + 6; i++)
         queue_record(1, POS_TOP, 1, POS_TOP, 0, POS_TOP, POS_TOP, i == MAX_GROUP_ITEMS + 5);
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         if (p == 4) idle_on = 1'b0;
         mn = ($urandom_range(0, 1) == 0) ? longint'(-1)
                                          : longint'($urandom_range(0, 3000));
         mx = ($urandom_range(0, 7) == 0) ? longint'(-1)
                                          : (mn < 0 ? longint'(0) : mn)
                                            + longint'($urandom_range(0, 40000));
         set_filter(mn, mx,
                    pick_limit(200, 2000), pick_limit(0, 100), pick_limit(100, 3000),
                    longint'($urandom_range(50, 100)));
         target = pushed_total + 40;
         while (pushed_total < target)
            queue_group(($urandom_range(0, 9) == 0) ? $urandom_range(5, 20)
                                                    : $urandom_range(1, 4));
         wait_idle();
      end

      $display("%0d records, %0d kept groups; rejects by reason 1-7: %0d %0d %0d %0d %0d %0d %0d",
               accepted_total, reason_seen[0], reason_seen[1], reason_seen[2], reason_seen[3],
               reason_seen[4], reason_seen[5], reason_seen[6], reason_seen[7]);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("timeout with %0d verdicts outstanding", verdict_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
